// ===== hdl/akc_pkg.sv =====
// shared types, constants and window arithmetic for the adc ladder key classifier
// used by every module under hdl; no dependencies
package akc_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int MV_W        = 12;
  localparam int KEY_W       = 3;
  localparam int KEY_MAX     = 4;
  localparam int REG_COUNT   = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 12;
  localparam int BND_W       = 14;

  localparam int KEY_COUNT_DEF            = 4;
  localparam int SAMPLES_PER_DECISION_DEF = 4;
  localparam int HYSTERESIS_MV_DEF        = 12;
  localparam int QUEUE_DEPTH_DEF          = 8;

  localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(4);

  // level conversion mv = raw * 3100 / 4095 by reciprocal multiply
  localparam int SCALE_NUM    = 3100;
  localparam int SCALE_DEN    = 4095;
  localparam int SCALE_PROD_W = 24;
  localparam int SCALE_SH     = 36;
  localparam longint unsigned SCALE_M =
    ((64'd1 << SCALE_SH) + SCALE_DEN - 1) / SCALE_DEN;
  localparam int SCALE_MW     = 25;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
  } win_t;

  typedef struct packed {
    logic signed [BND_W-1:0] wlo;
    logic signed [BND_W-1:0] whi;
    logic signed [BND_W-1:0] nlo;
    logic signed [BND_W-1:0] nhi;
  } bounds_t;

  typedef struct packed {
    logic       push;
    logic [2:0] inflight;
  } front_stat_t;

  localparam win_t [KEY_MAX-1:0] WIN_RESET = '{
    '{lo: 12'd447, hi: 12'd547},
    '{lo: 12'd250, hi: 12'd447},
    '{lo: 12'd150, hi: 12'd250},
    '{lo: 12'd0,   hi: 12'd150}
  };

  // widened and narrowed windows of one key
  function automatic bounds_t calc_bounds(win_t w, logic signed [BND_W-1:0] hyst);
    logic signed [BND_W-1:0] lo_s;
    logic signed [BND_W-1:0] hi_s;
    logic signed [BND_W-1:0] d;
    logic signed [BND_W-1:0] q;
    logic signed [BND_W-1:0] h;
    logic signed [BND_W-1:0] mid;
    bounds_t b;
    lo_s = $signed({{(BND_W-CFG_DATA_W){1'b0}}, w.lo});
    hi_s = $signed({{(BND_W-CFG_DATA_W){1'b0}}, w.hi});
    d = hi_s - lo_s;
    // quarter truncated toward zero
    q = (d + (d[BND_W-1] ? BND_W'(3) : BND_W'(0))) >>> 2;
    h = (q < hyst) ? q : hyst;
    if (h < BND_W'(1)) begin
      h = BND_W'(1);
    end
    b.wlo = lo_s - h;
    b.whi = hi_s + h;
    b.nlo = (w.lo != '0) ? lo_s + h : '0;
    b.nhi = hi_s - h;
    if (b.nhi < b.nlo) begin
      mid   = (lo_s + hi_s) >>> 1;
      b.nlo = mid - BND_W'(1);
      b.nhi = mid + BND_W'(1);
    end
    return b;
  endfunction

endpackage

// ===== hdl/adc_ladder_key_classifier.sv =====
// top level of the adc ladder keypad classifier: config registers, credit and wiring
// depends on akc_pkg, akc_front, akc_fifo, akc_back
//
// One raw sample word is taken per clock while in_ready is high. Every SAMPLES_PER_DECISION
// good samples form a group whose truncated average is scaled to millivolts and matched
// against the key windows; a read error drops the group in progress and yields nothing.
// A result word passes accumulate, average, scale, convert, queue and the result register.
// Input ready is withheld only while the
// QUEUE_DEPTH-entry level queue plus the words in the conversion pipeline could fill
// it, so with the result side taking every word the block sustains one sample per
// cycle at any group size. The user must write window registers via cfg_we, cfg_index
// and cfg_wdata only with no group in flight (unchecked); indexes 8 and up are ignored.
module adc_ladder_key_classifier #(
  parameter int KEY_COUNT            = akc_pkg::KEY_COUNT_DEF,
  parameter int SAMPLES_PER_DECISION = akc_pkg::SAMPLES_PER_DECISION_DEF,
  parameter int HYSTERESIS_MV        = akc_pkg::HYSTERESIS_MV_DEF,
  parameter int QUEUE_DEPTH          = akc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [akc_pkg::SAMPLE_W-1:0]   in_raw_sample,
  input  logic                           in_read_error,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [akc_pkg::MV_W-1:0]       out_level_mv,
  output logic [akc_pkg::KEY_W-1:0]      out_pressed_key,
  output logic                           out_key_changed,
  input  logic                           cfg_we,
  input  logic [akc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [akc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W  = QCNT_W + 1;

  akc_pkg::win_t [akc_pkg::KEY_MAX-1:0] win_r, win_nxt;
  akc_pkg::front_stat_t                 fstat;
  logic [akc_pkg::MV_W-1:0]             f_mv;
  logic [akc_pkg::MV_W-1:0]             q_mv;
  logic                                 q_empty;
  logic                                 q_pop;
  logic [QCNT_W-1:0]                    q_count;
  logic [OCC_W-1:0]                     occ;
  logic                                 in_acc;

  always_comb begin
    win_nxt = win_r;
    if (cfg_we && cfg_index < akc_pkg::CFG_IDX_W'(akc_pkg::REG_COUNT)) begin
      if (cfg_index[0]) begin
        win_nxt[cfg_index[2:1]].hi = cfg_wdata;
      end else begin
        win_nxt[cfg_index[2:1]].lo = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= akc_pkg::WIN_RESET;
    end else begin
      win_r <= win_nxt;
    end
  end

  // words in the pipeline hold a queue slot each
  assign occ      = OCC_W'(q_count) + OCC_W'(fstat.inflight);
  assign in_ready = (occ < OCC_W'(QUEUE_DEPTH));
  assign in_acc   = in_valid && in_ready;

  akc_front #(
    .SAMPLES_PER_DECISION(SAMPLES_PER_DECISION)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .raw_sample (in_raw_sample),
    .read_error (in_read_error),
    .stat       (fstat),
    .mv         (f_mv)
  );

  akc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fstat.push),
    .wdata (f_mv),
    .pop   (q_pop),
    .rdata (q_mv),
    .empty (q_empty),
    .count (q_count)
  );

  akc_back #(
    .KEY_COUNT     (KEY_COUNT),
    .HYSTERESIS_MV (HYSTERESIS_MV)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .win             (win_r),
    .q_mv            (q_mv),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level_mv    (out_level_mv),
    .out_pressed_key (out_pressed_key),
    .out_key_changed (out_key_changed)
  );

endmodule

// ===== hdl/akc_front.sv =====
// front end: sample accumulation, group average and millivolt conversion pipeline
// depends on akc_pkg
module akc_front #(
  parameter int SAMPLES_PER_DECISION = akc_pkg::SAMPLES_PER_DECISION_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_acc,
  input  logic [akc_pkg::SAMPLE_W-1:0] raw_sample,
  input  logic                         read_error,
  output akc_pkg::front_stat_t         stat,
  output logic [akc_pkg::MV_W-1:0]     mv
);

  localparam int SUM_W  = $clog2(SAMPLES_PER_DECISION * 4095 + 1);
  localparam int CNT_W  = $clog2(SAMPLES_PER_DECISION + 1);
  localparam int AVG_SH = SUM_W + $clog2(SAMPLES_PER_DECISION);
  localparam int AVG_MW = AVG_SH + 1;
  localparam longint unsigned AVG_M =
    ((64'd1 << AVG_SH) + SAMPLES_PER_DECISION - 1) / SAMPLES_PER_DECISION;
  localparam int P1_W   = SUM_W + AVG_MW;
  localparam int P3_W   = akc_pkg::SCALE_PROD_W + akc_pkg::SCALE_MW;

  logic [SUM_W-1:0]                     sum_r, sum_nxt;
  logic [CNT_W-1:0]                     cnt_r, cnt_nxt;
  logic [SUM_W-1:0]                     grp_r, grp_nxt;
  logic                                 grp_v_r, grp_v_nxt;
  logic [akc_pkg::SAMPLE_W-1:0]         avg_r;
  logic                                 avg_v_r;
  logic [akc_pkg::SCALE_PROD_W-1:0]     prod_r;
  logic                                 prod_v_r;
  logic [akc_pkg::MV_W-1:0]             mv_r;
  logic                                 mv_v_r;
  logic [SUM_W-1:0]                     sum_add;
  logic                                 last;
  logic [P1_W-1:0]                      p1;
  logic [P3_W-1:0]                      p3;

  assign sum_add = sum_r + SUM_W'(raw_sample);
  assign last    = (cnt_r == CNT_W'(SAMPLES_PER_DECISION - 1));

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    grp_nxt   = grp_r;
    grp_v_nxt = 1'b0;
    if (in_acc) begin
      if (read_error) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else if (last) begin
        sum_nxt   = '0;
        cnt_nxt   = '0;
        grp_nxt   = sum_add;
        grp_v_nxt = 1'b1;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  assign p1 = P1_W'(grp_r) * P1_W'(AVG_M);
  assign p3 = P3_W'(prod_r) * P3_W'(akc_pkg::SCALE_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cnt_r    <= '0;
      grp_v_r  <= 1'b0;
      avg_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
      mv_v_r   <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      grp_v_r  <= grp_v_nxt;
      avg_v_r  <= grp_v_r;
      prod_v_r <= avg_v_r;
      mv_v_r   <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    avg_r  <= p1[AVG_SH +: akc_pkg::SAMPLE_W];
    prod_r <= akc_pkg::SCALE_PROD_W'(avg_r) *
              akc_pkg::SCALE_PROD_W'(akc_pkg::SCALE_NUM);
    mv_r   <= p3[akc_pkg::SCALE_SH +: akc_pkg::MV_W];
  end

  assign stat.push     = mv_v_r;
  assign stat.inflight = 3'(grp_v_r) + 3'(avg_v_r) + 3'(prod_v_r) + 3'(mv_v_r);
  assign mv            = mv_r;

endmodule

// ===== hdl/akc_fifo.sv =====
// level word queue between the front end and the classifier
// depends on akc_pkg
module akc_fifo #(
  parameter int DEPTH = akc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [akc_pkg::MV_W-1:0]     wdata,
  input  logic                         pop,
  output logic [akc_pkg::MV_W-1:0]     rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [akc_pkg::MV_W-1:0] mem [DEPTH];
  logic [akc_pkg::MV_W-1:0] rd_r;
  logic [PTR_W-1:0]         wp_r, wp_nxt;
  logic [PTR_W-1:0]         rp_r, rp_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // head word is fetched ahead, with bypass when it is written in the same cycle
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
    if (push && wp_r == rp_nxt) begin
      rd_r <= wdata;
    end else begin
      rd_r <= mem[rp_nxt];
    end
  end

  assign rdata = rd_r;
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == CNT_W'(DEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && cnt_r == '0))
    else $error("queue underflow");

endmodule

// ===== hdl/akc_back.sv =====
// back end: key selection with hysteresis and the result register
// depends on akc_pkg
module akc_back #(
  parameter int KEY_COUNT     = akc_pkg::KEY_COUNT_DEF,
  parameter int HYSTERESIS_MV = akc_pkg::HYSTERESIS_MV_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  akc_pkg::win_t [akc_pkg::KEY_MAX-1:0] win,
  input  logic [akc_pkg::MV_W-1:0]             q_mv,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [akc_pkg::MV_W-1:0]             out_level_mv,
  output logic [akc_pkg::KEY_W-1:0]            out_pressed_key,
  output logic                                 out_key_changed
);

  localparam logic signed [akc_pkg::BND_W-1:0] HYST = akc_pkg::BND_W'(HYSTERESIS_MV);

  akc_pkg::bounds_t [akc_pkg::KEY_MAX-1:0] bnd_r;
  logic [akc_pkg::KEY_W-1:0]               cur_r, cur_nxt;
  logic                                    ov_r, ov_nxt;
  logic [akc_pkg::MV_W-1:0]                lvl_r;
  logic [akc_pkg::KEY_W-1:0]               key_r;
  logic                                    chg_r;
  logic signed [akc_pkg::BND_W-1:0]        mv_s;
  logic [akc_pkg::KEY_W-1:0]               sel;
  logic                                    keep;
  akc_pkg::bounds_t                        cur_b;

  always_ff @(posedge clk) begin
    for (int k = 0; k < akc_pkg::KEY_MAX; k++) begin
      bnd_r[k] <= akc_pkg::calc_bounds(win[k], HYST);
    end
  end

  assign mv_s  = $signed({{(akc_pkg::BND_W-akc_pkg::MV_W){1'b0}}, q_mv});
  assign cur_b = bnd_r[cur_r[1:0]];

  always_comb begin
    keep = (cur_r < akc_pkg::KEY_W'(KEY_COUNT)) &&
           (mv_s >= cur_b.wlo) && (mv_s <= cur_b.whi);
    sel  = akc_pkg::NO_KEY;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (mv_s >= bnd_r[i].nlo && mv_s <= bnd_r[i].nhi) begin
        sel = akc_pkg::KEY_W'(i);
      end
    end
    if (keep) begin
      sel = cur_r;
    end
  end

  assign q_pop = !q_empty && (!ov_r || out_ready);

  always_comb begin
    cur_nxt = cur_r;
    ov_nxt  = ov_r;
    if (q_pop) begin
      cur_nxt = sel;
      ov_nxt  = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= akc_pkg::NO_KEY;
      ov_r  <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lvl_r <= q_mv;
      key_r <= sel;
      chg_r <= (sel != cur_r);
    end
  end

  assign out_valid       = ov_r;
  assign out_level_mv    = lvl_r;
  assign out_pressed_key = key_r;
  assign out_key_changed = chg_r;

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (key_r <= akc_pkg::NO_KEY))
    else $error("pressed key out of range");

  a_cur_follows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (cur_r == key_r))
    else $error("current key not updated with decision");

  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (chg_r == (key_r != $past(cur_r))))
    else $error("change flag wrong");

endmodule
